// File: rtl/bmprgba_pkg.sv
// Shared types and constants for the BMP to RGBA stream decoder.
// Holds the header byte offsets, status codes, result record and bus widths.
// No dependencies.
package bmprgba_pkg;

    // Byte position counter width; saturates, and every position at or above
    // 2^16 compares the same against the 16-bit pixel offset and the header size.
    localparam int unsigned POS_W = 17;
    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t HEADER_BYTES = pos_t'(54);
    localparam pos_t POS_SIG_B    = pos_t'(0);
    localparam pos_t POS_SIG_M    = pos_t'(1);
    localparam pos_t POS_OFS_LO   = pos_t'(10);
    localparam pos_t POS_OFS_HI   = pos_t'(11);
    localparam pos_t POS_WID_LO   = pos_t'(18);
    localparam pos_t POS_WID_HI   = pos_t'(19);
    localparam pos_t POS_HGT_LO   = pos_t'(22);
    localparam pos_t POS_HGT_HI   = pos_t'(23);
    localparam pos_t POS_DEPTH    = pos_t'(28);

    localparam logic [7:0] SIG_CHAR_B = 8'h42;
    localparam logic [7:0] SIG_CHAR_M = 8'h4D;
    localparam logic [7:0] DEPTH_24   = 8'd24;
    localparam logic [7:0] DEPTH_32   = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    localparam int unsigned SCAN_W = 18;
    localparam int unsigned IDX_W  = 24;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_SHORT_HDR = 3'd1,
        STATUS_BAD_SIG   = 3'd2,
        STATUS_BAD_DEPTH = 3'd3,
        STATUS_TRUNCATED = 3'd4,
        STATUS_TOO_LARGE = 3'd5
    } status_t;

    typedef enum logic {
        KIND_PIXEL  = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   pixel_index;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        status_t            status;
        logic [15:0]        image_width;
        logic [15:0]        image_height;
        logic               final_res;
    } result_t;

    // pixel_index, red, green, blue, alpha, status, image_width, image_height
    localparam int unsigned TDATA_BITS = IDX_W + 4 * 8 + 3 + 16 + 16;
    localparam int unsigned TDATA_W    = ((TDATA_BITS + 7) / 8) * 8;

endpackage

// File: rtl/bmp_to_rgba_stream_decoder.sv
// Each result beat is written into the result queue when its byte is accepted; a status
// beat that follows a pixel beat from the same byte is queued behind it.
// Throughput: one byte per cycle; a four-entry result queue takes up to two beats
// per byte and input ready drops while it holds more than two.
// Reset (rst_n, asynchronous, active low) clears the header fields, counters and
// queue; the header fields and counters also return to their reset values after each byte marked tlast.
module bmp_to_rgba_stream_decoder #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // data_byte
    input  logic                            s_tlast,   // last_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_index[23:0], red, green, blue, alpha, status[2:0], image_width,
    // image_height, zero fill
    output logic [bmprgba_pkg::TDATA_W-1:0] m_tdata,
    output logic                            m_tuser,   // kind
    output logic                            m_tlast    // final_res
);
    import bmprgba_pkg::*;

    localparam logic [15:0] MAX_W = 16'(MAX_WIDTH);
    localparam logic [15:0] MAX_H = 16'(MAX_HEIGHT);
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // decoder state
    pos_t              pos_reg, pos_next;
    logic [15:0]       offset_reg, offset_next;
    logic [15:0]       width_reg, width_next;
    logic [15:0]       height_reg, height_next;
    logic [7:0]        depth_reg, depth_next;
    logic              sig_ok_reg, sig_ok_next;
    logic [15:0]       column_reg, column_next;
    logic [15:0]       row_reg, row_next;
    logic [SCAN_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [SCAN_W-1:0] scan_len_reg, scan_len_next;
    logic [15:0]       held_bg_reg, held_bg_next;
    logic [1:0]        channel_reg, channel_next;
    logic [IDX_W-1:0]  row_base_reg, row_base_next;

    // result queue
    result_t           queue_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic              accept, pop;
    logic              depth_ok_cur, too_large_cur, active;
    logic              depth_ok_new, too_large_new;
    logic              emit_pixel;
    logic [SCAN_W-1:0] scan_inc, scan_raw;
    logic [IDX_W-1:0]  base_prod;
    pos_t              start_pos;
    status_t           status_val;
    result_t           pixel_res, status_res, first_res;
    logic [1:0]        push_n;
    logic [QPTR_W-1:0] wr_ptr_second;

    assign accept = s_tvalid && s_tready;
    assign pop    = m_tvalid && m_tready;
    assign s_tready = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign m_tvalid = (count_reg != '0);

    assign depth_ok_cur  = (depth_reg == DEPTH_24) || (depth_reg == DEPTH_32);
    assign too_large_cur = (width_reg > MAX_W) || (height_reg > MAX_H);
    assign active = sig_ok_reg && depth_ok_cur && (pos_reg >= {1'b0, offset_reg}) &&
                    (width_reg != '0) && (row_reg < height_reg);

    // scanline length padded to 4 bytes, and the top-down index of the first file row
    always_comb
    begin
        if (depth_reg == DEPTH_32)
        begin
            scan_raw = {width_reg, 2'b00} + SCAN_W'(3);
        end
        else
        begin
            scan_raw = {1'b0, width_reg, 1'b0} + {2'b00, width_reg} + SCAN_W'(3);
        end
    end
    assign base_prod = {8'd0, height_reg - 16'd1} * {8'd0, width_reg};
    assign scan_inc  = scan_cnt_reg + SCAN_W'(1);

    always_comb
    begin
        pos_next      = pos_reg;
        offset_next   = offset_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        depth_next    = depth_reg;
        sig_ok_next   = sig_ok_reg;
        column_next   = column_reg;
        row_next      = row_reg;
        scan_cnt_next = scan_cnt_reg;
        scan_len_next = scan_len_reg;
        held_bg_next  = held_bg_reg;
        channel_next  = channel_reg;
        row_base_next = row_base_reg;
        emit_pixel    = 1'b0;

        if (pos_reg < HEADER_BYTES)
        begin
            case (pos_reg)
                POS_SIG_B:  sig_ok_next = (s_tdata == SIG_CHAR_B);
                POS_SIG_M:  sig_ok_next = sig_ok_reg && (s_tdata == SIG_CHAR_M);
                POS_OFS_LO: offset_next = {offset_reg[15:8], s_tdata};
                POS_OFS_HI: offset_next = {s_tdata, offset_reg[7:0]};
                POS_WID_LO: width_next  = {width_reg[15:8], s_tdata};
                POS_WID_HI: width_next  = {s_tdata, width_reg[7:0]};
                POS_HGT_LO: height_next = {height_reg[15:8], s_tdata};
                POS_HGT_HI: height_next = {s_tdata, height_reg[7:0]};
                POS_DEPTH:  depth_next  = s_tdata;
                default:    ;
            endcase
            // settles before the header ends since the fields stop changing at byte 28
            scan_len_next = scan_raw & ~SCAN_W'(3);
            row_base_next = base_prod;
        end
        else if (active)
        begin
            if (column_reg < width_reg)
            begin
                case (channel_reg)
                    2'd0:
                    begin
                        held_bg_next = {held_bg_reg[15:8], s_tdata};
                        channel_next = 2'd1;
                    end
                    2'd1:
                    begin
                        held_bg_next = {s_tdata, held_bg_reg[7:0]};
                        channel_next = 2'd2;
                    end
                    2'd2:
                    begin
                        emit_pixel = !too_large_cur;
                        if (depth_reg == DEPTH_24)
                        begin
                            column_next  = column_reg + 16'd1;
                            channel_next = 2'd0;
                        end
                        else
                        begin
                            channel_next = 2'd3;
                        end
                    end
                    default:
                    begin
                        // drop the alpha byte of a 32-bit pixel
                        column_next  = column_reg + 16'd1;
                        channel_next = 2'd0;
                    end
                endcase
            end
            scan_cnt_next = scan_inc;
            if (scan_inc >= scan_len_reg)
            begin
                row_next      = row_reg + 16'd1;
                column_next   = '0;
                scan_cnt_next = '0;
                channel_next  = 2'd0;
                row_base_next = row_base_reg - {8'd0, width_reg};
            end
        end

        if (pos_reg != '1)
        begin
            pos_next = pos_reg + pos_t'(1);
        end
    end

    // Status uses the header and row counters as they stand after this byte.
    logic [15:0] width_new, height_new, row_new;
    logic [7:0]  depth_new;
    logic        sig_new;
    pos_t        total_pos;

    always_comb
    begin
        width_new  = width_reg;
        height_new = height_reg;
        depth_new  = depth_reg;
        sig_new    = sig_ok_reg;
        row_new    = row_reg;
        if (pos_reg < HEADER_BYTES)
        begin
            width_new  = width_next;
            height_new = height_next;
            depth_new  = depth_next;
            sig_new    = sig_ok_next;
        end
        else if (active && (scan_inc >= scan_len_reg))
        begin
            row_new = row_reg + 16'd1;
        end
        total_pos = (pos_reg != '1) ? pos_reg + pos_t'(1) : pos_reg;
    end

    assign depth_ok_new  = (depth_new == DEPTH_24) || (depth_new == DEPTH_32);
    assign too_large_new = (width_new > MAX_W) || (height_new > MAX_H);
    assign start_pos = ({1'b0, offset_reg} > HEADER_BYTES) ? {1'b0, offset_reg} : HEADER_BYTES;

    always_comb
    begin
        if (total_pos < HEADER_BYTES)
        begin
            status_val = STATUS_SHORT_HDR;
        end
        else if (!sig_new)
        begin
            status_val = STATUS_BAD_SIG;
        end
        else if (!depth_ok_new)
        begin
            status_val = STATUS_BAD_DEPTH;
        end
        else if ((total_pos < start_pos) || ((width_new != '0) && (row_new < height_new)))
        begin
            status_val = STATUS_TRUNCATED;
        end
        else if (too_large_new)
        begin
            status_val = STATUS_TOO_LARGE;
        end
        else
        begin
            status_val = STATUS_OK;
        end
    end

    always_comb
    begin
        pixel_res              = '0;
        pixel_res.kind         = KIND_PIXEL;
        pixel_res.pixel_index  = row_base_reg + {8'd0, column_reg};
        pixel_res.red          = s_tdata;
        pixel_res.green        = held_bg_reg[15:8];
        pixel_res.blue         = held_bg_reg[7:0];
        pixel_res.alpha        = ALPHA_OPAQUE;
        pixel_res.status       = STATUS_OK;

        status_res              = '0;
        status_res.kind         = KIND_STATUS;
        status_res.status       = status_val;
        status_res.image_width  = width_new;
        status_res.image_height = height_new;
        status_res.final_res    = 1'b1;

        first_res = emit_pixel ? pixel_res : status_res;
        push_n    = accept ? (2'(emit_pixel) + 2'(s_tlast)) : 2'd0;
    end

    assign wr_ptr_second = wr_ptr_reg + QPTR_W'(1);
    assign count_next = count_reg + QCNT_W'(push_n) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            offset_reg   <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            depth_reg    <= '0;
            sig_ok_reg   <= 1'b0;
            column_reg   <= '0;
            row_reg      <= '0;
            scan_cnt_reg <= '0;
            scan_len_reg <= '0;
            held_bg_reg  <= '0;
            channel_reg  <= 2'd0;
            row_base_reg <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (s_tlast)
                begin
                    // restart for the next file
                    pos_reg      <= '0;
                    offset_reg   <= '0;
                    width_reg    <= '0;
                    height_reg   <= '0;
                    depth_reg    <= '0;
                    sig_ok_reg   <= 1'b0;
                    column_reg   <= '0;
                    row_reg      <= '0;
                    scan_cnt_reg <= '0;
                    scan_len_reg <= '0;
                    held_bg_reg  <= '0;
                    channel_reg  <= 2'd0;
                    row_base_reg <= '0;
                end
                else
                begin
                    pos_reg      <= pos_next;
                    offset_reg   <= offset_next;
                    width_reg    <= width_next;
                    height_reg   <= height_next;
                    depth_reg    <= depth_next;
                    sig_ok_reg   <= sig_ok_next;
                    column_reg   <= column_next;
                    row_reg      <= row_next;
                    scan_cnt_reg <= scan_cnt_next;
                    scan_len_reg <= scan_len_next;
                    held_bg_reg  <= held_bg_next;
                    channel_reg  <= channel_next;
                    row_base_reg <= row_base_next;
                end
            end
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // queue payload: first beat at the write pointer, status behind it when both go in
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            if ((push_n != 2'd0) && (QPTR_W'(i) == wr_ptr_reg))
            begin
                queue_reg[i] <= first_res;
            end
            else if ((push_n == 2'd2) && (QPTR_W'(i) == wr_ptr_second))
            begin
                queue_reg[i] <= status_res;
            end
        end
    end

    result_t head;
    assign head = queue_reg[rd_ptr_reg];

    assign m_tdata = {(TDATA_W - TDATA_BITS)'(0), head.image_height, head.image_width,
                      head.status, head.alpha, head.blue, head.green, head.red,
                      head.pixel_index};
    assign m_tuser = head.kind;
    assign m_tlast = head.final_res;

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (pos_reg == '0 && row_reg == '0 && channel_reg == 2'd0))
        else $error("decoder did not return to start after last byte");

    a_kind_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == m_tlast))
        else $error("status beat and final flag disagree");

    a_pixel_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_PIXEL)) |-> (head.alpha == ALPHA_OPAQUE))
        else $error("pixel beat with non-opaque alpha");

    a_no_pixel_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (pos_reg < HEADER_BYTES)) |-> !emit_pixel)
        else $error("pixel emitted during header");
`endif

endmodule

// File: dv/tb_top.sv
// Testbench for the BMP to RGBA stream decoder: streams directed and random BMP files
// one byte per beat, predicts every pixel and status beat, and checks the output stream.
// Depends on rtl/bmprgba_pkg.sv and rtl/bmp_to_rgba_stream_decoder.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bmprgba_pkg::*;

    localparam int unsigned MAX_W = 4096;
    localparam int unsigned MAX_H = 4096;
    localparam int RANDOM_BYTES   = 250;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int REPORT_MAX     = 10;
    localparam int NO_TYPED       = -1;
    localparam int NUM_DIRECTED   = 22;
    localparam int HOLD_LEN       = 100;

    // m_tdata field positions, lowest first
    localparam int RED_LSB    = IDX_W;
    localparam int GREEN_LSB  = RED_LSB + 8;
    localparam int BLUE_LSB   = RED_LSB + 16;
    localparam int ALPHA_LSB  = RED_LSB + 24;
    localparam int STATUS_LSB = RED_LSB + 32;
    localparam int WIDTH_LSB  = STATUS_LSB + 3;
    localparam int HEIGHT_LSB = WIDTH_LSB + 16;
    localparam int FILL_LSB   = HEIGHT_LSB + 16;

    typedef struct packed {
        logic [7:0]  sig0;
        logic [7:0]  sig1;
        logic [15:0] ofs;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  depth;
        int          len;      // total bytes; 0 for a complete file
        int          extra;    // bytes past the last row of a complete file
        int          status;   // typed status, or NO_TYPED
    } bmp_file_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [7:0]          s_tdata  = 8'd0;
    logic                s_tlast  = 1'b0;
    logic                m_tready = 1'b0;
    logic                s_tready;
    logic                m_tvalid;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    bmp_to_rgba_stream_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Decoder state mirrored for prediction
    logic [31:0] byte_pos;
    logic [15:0] pix_ofs;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic [7:0]  img_depth;
    logic        sig_ok;
    logic [15:0] col_cnt;
    logic [15:0] row_cnt;
    logic [17:0] scan_cnt;
    logic [15:0] held_bg;
    logic [1:0]  chan_cnt;

    result_t     decoded_q[$];
    bmp_file_t   directed_files [NUM_DIRECTED];
    result_t     got_beat;
    result_t     want_beat;

    int mismatches    = 0;
    int beats_seen    = 0;
    int pixels_seen   = 0;
    int statuses_seen = 0;
    int files_sent    = 0;
    int bytes_sent    = 0;
    int cycles        = 0;
    int hold_reqs     = 0;
    int holds_done    = 0;
    int hold_left     = 0;
    int phase_left    = 0;
    int ready_level   = 4;
    int burst_left    = 0;
    bit steady        = 1'b0;

    function automatic void clear_decoder();
        byte_pos  = '0;
        pix_ofs   = '0;
        img_w     = '0;
        img_h     = '0;
        img_depth = '0;
        sig_ok    = 1'b0;
        col_cnt   = '0;
        row_cnt   = '0;
        scan_cnt  = '0;
        held_bg   = '0;
        chan_cnt  = '0;
    endfunction

    function automatic bit depth_good();
        return img_depth == DEPTH_24 || img_depth == DEPTH_32;
    endfunction

    function automatic bit too_big();
        return 32'(img_w) > MAX_W || 32'(img_h) > MAX_H;
    endfunction

    // Advance the mirrored decoder by one byte and queue the beats it owes
    function automatic void decode_byte(input logic [7:0] b, input logic is_last,
                                        input int typed_st);
        logic [31:0] nch;
        logic [31:0] scan;
        logic [31:0] start;
        logic [63:0] idx;
        logic [2:0]  st;
        result_t     r;
        if (byte_pos < 32'(HEADER_BYTES)) begin
            case (byte_pos)
                32'(POS_SIG_B):  sig_ok = (b == SIG_CHAR_B);
                32'(POS_SIG_M):  if (b != SIG_CHAR_M) sig_ok = 1'b0;
                32'(POS_OFS_LO): pix_ofs[7:0] = b;
                32'(POS_OFS_HI): pix_ofs[15:8] = b;
                32'(POS_WID_LO): img_w[7:0] = b;
                32'(POS_WID_HI): img_w[15:8] = b;
                32'(POS_HGT_LO): img_h[7:0] = b;
                32'(POS_HGT_HI): img_h[15:8] = b;
                32'(POS_DEPTH):  img_depth = b;
                default: ;
            endcase
        end else if (sig_ok && depth_good() && byte_pos >= 32'(pix_ofs) && img_w != 16'd0
                     && row_cnt < img_h) begin
            nch  = 32'(img_depth >> 3);
            scan = (32'(img_w) * nch + 32'd3) & ~32'd3;
            if (col_cnt < img_w) begin
                case (chan_cnt)
                    2'd0: begin
                        held_bg[7:0] = b;
                        chan_cnt = 2'd1;
                    end
                    2'd1: begin
                        held_bg[15:8] = b;
                        chan_cnt = 2'd2;
                    end
                    2'd2: begin
                        if (!too_big()) begin
                            idx = 64'(img_h - 16'd1 - row_cnt) * 64'(img_w) + 64'(col_cnt);
                            r = '0;
                            r.kind        = KIND_PIXEL;
                            r.pixel_index = idx[IDX_W-1:0];
                            r.red         = b;
                            r.green       = held_bg[15:8];
                            r.blue        = held_bg[7:0];
                            r.alpha       = ALPHA_OPAQUE;
                            decoded_q.push_back(r);
                        end
                        if (nch == 32'd3) begin
                            col_cnt++;
                            chan_cnt = 2'd0;
                        end else begin
                            chan_cnt = 2'd3;
                        end
                    end
                    default: begin
                        // drop the alpha byte of a 32-bit pixel
                        col_cnt++;
                        chan_cnt = 2'd0;
                    end
                endcase
            end
            scan_cnt++;
            if (32'(scan_cnt) >= scan) begin
                row_cnt++;
                col_cnt  = '0;
                scan_cnt = '0;
                chan_cnt = '0;
            end
        end

        if (byte_pos != 32'hFFFF_FFFF) byte_pos++;

        if (is_last) begin
            start = (32'(pix_ofs) > 32'(HEADER_BYTES)) ? 32'(pix_ofs) : 32'(HEADER_BYTES);
            if (byte_pos < 32'(HEADER_BYTES))
                st = STATUS_SHORT_HDR;
            else if (!sig_ok)
                st = STATUS_BAD_SIG;
            else if (!depth_good())
                st = STATUS_BAD_DEPTH;
            else if (byte_pos < start || (img_w != 16'd0 && row_cnt < img_h))
                st = STATUS_TRUNCATED;
            else if (too_big())
                st = STATUS_TOO_LARGE;
            else
                st = STATUS_OK;
            if (typed_st != NO_TYPED) st = typed_st[2:0];
            r = '0;
            r.kind         = KIND_STATUS;
            r.status       = status_t'(st);
            r.image_width  = img_w;
            r.image_height = img_h;
            r.final_res    = 1'b1;
            decoded_q.push_back(r);
            clear_decoder();
        end
    endfunction

    function automatic int file_length(input bmp_file_t f);
        int start;
        int nch;
        int scan;
        if (f.len > 0) return f.len;
        start = (32'(f.ofs) > 32'(HEADER_BYTES)) ? int'(f.ofs) : int'(HEADER_BYTES);
        nch   = (f.depth == DEPTH_32) ? 4 : 3;
        scan  = (int'(f.width) * nch + 3) & ~3;
        return start + scan * int'(f.height) + f.extra;
    endfunction

    function automatic bmp_file_t random_bmp();
        bmp_file_t f;
        int pick;
        int full;
        pick     = int'($urandom_range(0, 99));
        f.sig0   = SIG_CHAR_B;
        f.sig1   = SIG_CHAR_M;
        f.depth  = ($urandom_range(0, 1) == 0) ? DEPTH_24 : DEPTH_32;
        f.width  = 16'($urandom_range(1, 6));
        f.height = 16'($urandom_range(0, 4));
        f.ofs    = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 53))
                                               : 16'($urandom_range(54, 64));
        f.len    = 0;
        f.extra  = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 5)) : 0;
        f.status = NO_TYPED;
        if (pick < 6) begin
            f.len = int'($urandom_range(1, 53));
        end else if (pick < 11) begin
            f.sig0 = 8'($urandom);
            f.sig1 = 8'($urandom);
            f.len  = int'($urandom_range(54, 90));
        end else if (pick < 16) begin
            f.depth = 8'($urandom);
        end else if (pick < 26) begin
            // cut a well-formed file short
            full = file_length(f);
            if (full > 54) f.len = int'($urandom_range(54, full - 1));
        end else if (pick < 30) begin
            f.width  = 16'($urandom_range(MAX_W + 1, 65535));
            f.height = 16'd0;
        end else if (pick < 33) begin
            f.width  = 16'd0;
            f.height = 16'($urandom_range(MAX_H + 1, 65535));
        end else if (pick < 36) begin
            f.height = 16'($urandom_range(MAX_H + 1, 65535));
            f.len    = int'($urandom_range(54, 120));
        end else if (pick < 40) begin
            f.ofs = 16'($urandom);
            f.len = int'($urandom_range(54, 120));
        end else if (pick < 44) begin
            f.width  = 16'd0;
            f.height = 16'($urandom);
        end
        return f;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_last, input int typed_st);
        int gap;
        if (burst_left == 0) begin
            gap        = steady ? 0 : int'($urandom_range(0, 6));
            burst_left = int'($urandom_range(1, 40));
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        do @(posedge clk); while (!s_tready);
        decode_byte(b, is_last, typed_st);
        bytes_sent++;
    endtask

    task automatic send_file(input bmp_file_t f);
        int total;
        logic [7:0] b;
        total = file_length(f);
        for (int i = 0; i < total; i++) begin
            case (i)
                int'(POS_SIG_B):  b = f.sig0;
                int'(POS_SIG_M):  b = f.sig1;
                int'(POS_OFS_LO): b = f.ofs[7:0];
                int'(POS_OFS_HI): b = f.ofs[15:8];
                int'(POS_WID_LO): b = f.width[7:0];
                int'(POS_WID_HI): b = f.width[15:8];
                int'(POS_HGT_LO): b = f.height[7:0];
                int'(POS_HGT_HI): b = f.height[15:8];
                int'(POS_DEPTH):  b = f.depth;
                default:          b = 8'($urandom);
            endcase
            send_byte(b, i == total - 1, f.status);
        end
        files_sent++;
    endtask

    // Hold the input until every owed beat has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (decoded_q.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("Mismatch on beat %0d, %s: expected %0h, got %0h",
                         beats_seen, name, want, got);
        end
    endtask

    // Receiver: random readiness in phases, plus long hold-offs on request
    always @(posedge clk) begin
        if (holds_done != hold_reqs) begin
            holds_done = hold_reqs;
            hold_left  = HOLD_CYCLES;
        end
        if (phase_left == 0) begin
            ready_level = int'($urandom_range(1, 4));
            phase_left  = int'($urandom_range(16, 96));
        end
        phase_left--;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= (int'($urandom_range(1, 4)) <= ready_level);
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            beats_seen++;
            got_beat.kind         = kind_t'(m_tuser);
            got_beat.pixel_index  = m_tdata[IDX_W-1:0];
            got_beat.red          = m_tdata[RED_LSB +: 8];
            got_beat.green        = m_tdata[GREEN_LSB +: 8];
            got_beat.blue         = m_tdata[BLUE_LSB +: 8];
            got_beat.alpha        = m_tdata[ALPHA_LSB +: 8];
            got_beat.status       = status_t'(m_tdata[STATUS_LSB +: 3]);
            got_beat.image_width  = m_tdata[WIDTH_LSB +: 16];
            got_beat.image_height = m_tdata[HEIGHT_LSB +: 16];
            got_beat.final_res    = m_tlast;
            if (decoded_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Unexpected beat %0d: tuser=%0b tlast=%0b tdata=%h",
                             beats_seen, m_tuser, m_tlast, m_tdata);
            end else begin
                want_beat = decoded_q.pop_front();
                check_field("kind", 32'(want_beat.kind), 32'(got_beat.kind));
                check_field("pixel_index", 32'(want_beat.pixel_index),
                            32'(got_beat.pixel_index));
                check_field("red", 32'(want_beat.red), 32'(got_beat.red));
                check_field("green", 32'(want_beat.green), 32'(got_beat.green));
                check_field("blue", 32'(want_beat.blue), 32'(got_beat.blue));
                check_field("alpha", 32'(want_beat.alpha), 32'(got_beat.alpha));
                check_field("status", 32'(want_beat.status), 32'(got_beat.status));
                check_field("image_width", 32'(want_beat.image_width),
                            32'(got_beat.image_width));
                check_field("image_height", 32'(want_beat.image_height),
                            32'(got_beat.image_height));
                check_field("final_res", 32'(want_beat.final_res), 32'(got_beat.final_res));
                check_field("zero fill", 32'd0, 32'(m_tdata[TDATA_W-1:FILL_LSB]));
                if (want_beat.kind == KIND_PIXEL)
                    pixels_seen++;
                else
                    statuses_seen++;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still owed",
                     cycles, decoded_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int base;
        int nfile;
        clear_decoder();
        //                  sig0   sig1   ofs       width     height    depth  len extra status
        directed_files = '{
            '{8'h42, 8'h4D, 16'd54,   16'd2,    16'd2,    8'd24, 10,  0, STATUS_SHORT_HDR},
            '{8'h42, 8'h4D, 16'd54,   16'd2,    16'd2,    8'd24, 1,   0, STATUS_SHORT_HDR},
            '{8'h42, 8'h4D, 16'd54,   16'd7,    16'd9,    8'd24, 53,  0, STATUS_SHORT_HDR},
            '{8'h42, 8'h58, 16'd54,   16'd2,    16'd2,    8'd24, 60,  0, STATUS_BAD_SIG},
            '{8'h41, 8'h4D, 16'd54,   16'd2,    16'd2,    8'd24, 54,  0, STATUS_BAD_SIG},
            '{8'h42, 8'h4D, 16'd54,   16'd2,    16'd2,    8'd16, 70,  0, STATUS_BAD_DEPTH},
            '{8'h42, 8'h4D, 16'd54,   16'd2,    16'd2,    8'hFF, 54,  0, STATUS_BAD_DEPTH},
            '{8'h42, 8'h4D, 16'd54,   16'd3,    16'd2,    8'd24, 0,   0, STATUS_OK},
            '{8'h42, 8'h4D, 16'd54,   16'd2,    16'd2,    8'd32, 0,   0, STATUS_OK},
            '{8'h42, 8'h4D, 16'd10,   16'd1,    16'd1,    8'd24, 0,   0, STATUS_OK},
            '{8'h42, 8'h4D, 16'hFFFF, 16'd1,    16'd1,    8'd24, 100, 0, STATUS_TRUNCATED},
            '{8'h42, 8'h4D, 16'd54,   16'd4,    16'd3,    8'd24, 83,  0, STATUS_TRUNCATED},
            '{8'h42, 8'h4D, 16'd100,  16'd0,    16'd0,    8'd24, 80,  0, STATUS_TRUNCATED},
            '{8'h42, 8'h4D, 16'd54,   16'd0,    16'd3,    8'd24, 54,  0, STATUS_OK},
            '{8'h42, 8'h4D, 16'd54,   16'd5,    16'd0,    8'd24, 54,  0, STATUS_OK},
            '{8'h42, 8'h4D, 16'd54,   16'd4097, 16'd1,    8'd24, 120, 0, STATUS_TRUNCATED},
            '{8'h42, 8'h4D, 16'd54,   16'hFFFF, 16'd0,    8'd32, 54,  0, STATUS_TOO_LARGE},
            '{8'h42, 8'h4D, 16'd54,   16'd0,    16'hFFFF, 8'd24, 54,  0, STATUS_TOO_LARGE},
            '{8'h42, 8'h4D, 16'd54,   16'd3,    16'd2,    8'd24, 0,   7, STATUS_OK},
            '{8'h42, 8'h4D, 16'd60,   16'd5,    16'd3,    8'd24, 0,   2, NO_TYPED},
            '{8'h42, 8'h4D, 16'd54,   16'd4096, 16'd0,    8'd32, 54,  0, STATUS_OK},
            '{8'h42, 8'h4D, 16'd54,   16'd0,    16'd4096, 8'd24, 54,  0, STATUS_OK}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_files[i]) begin
            steady = ($urandom_range(0, 3) == 0);
            // stall the output through the longer files so the input backs up
            if (file_length(directed_files[i]) > HOLD_LEN) hold_reqs++;
            send_file(directed_files[i]);
        end
        wait_drained();

        base  = bytes_sent;
        nfile = 0;
        while (bytes_sent - base < RANDOM_BYTES) begin
            steady = ($urandom_range(0, 3) == 0);
            if (nfile == 5) hold_reqs++;
            send_file(random_bmp());
            nfile++;
            if (nfile % 8 == 0) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d files, %0d bytes: %0d pixel and %0d status beats checked.",
                 files_sent, bytes_sent, pixels_seen, statuses_seen);
        $display("Directed header errors, sizes and padding, then random files, %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && decoded_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
